[src/pcwrl_pkg.sv]
// pcwrl_pkg: shared constants, types and register codes for the rate limiter
// used by pcwrl_entry, pcwrl_table and per_client_window_rate_limiter_core
package pcwrl_pkg;

  localparam int CLIENT_ENTRIES   = 16;
  localparam int SLOTS_PER_CLIENT = 8;

  localparam int ID_W     = 31;
  localparam int TIME_W   = 32;
  localparam int WINDOW_W = 16;
  localparam int LIMIT_W  = 4;

  localparam int ENTRY_IDX_W = (CLIENT_ENTRIES > 1) ? $clog2(CLIENT_ENTRIES) : 1;
  localparam int SLOT_IDX_W  = (SLOTS_PER_CLIENT > 1) ? $clog2(SLOTS_PER_CLIENT) : 1;
  localparam int LIVE_W      = $clog2(SLOTS_PER_CLIENT + 1);
  localparam int CMP_W       = (LIVE_W > LIMIT_W) ? LIVE_W : LIMIT_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = WINDOW_W;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(5);
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW = 1'b0,
    CFG_LIMIT  = 1'b1
  } cfg_idx_t;

  // per-entry lookup status
  typedef struct packed {
    logic                  hit;
    logic                  avail;
    logic [LIVE_W-1:0]     live_cnt;
    logic                  free_found;
    logic [SLOT_IDX_W-1:0] free_idx;
  } entry_stat_t;

  // per-entry update command
  typedef struct packed {
    logic                  commit;
    logic                  claim;
    logic                  set_slot;
    logic [SLOT_IDX_W-1:0] slot_idx;
    logic [TIME_W-1:0]     deadline;
    logic [ID_W-1:0]       client;
  } entry_upd_t;

endpackage

[src/per_client_window_rate_limiter_core.sv]
// Per-client sliding-window rate limiter. Takes one request per cycle while the
// result register is not held by out_stall. Each result passes the input register,
// then the result register, where it is offered and can transfer out at the
// following edge at the earliest. All entry id compares and all slot deadline
// compares run in parallel between those registers, which sets the rate.
// Configuration writes are accepted at any time and must be made while idle.
// depends on pcwrl_pkg and pcwrl_table
module per_client_window_rate_limiter_core import pcwrl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ID_W-1:0]       in_client_id,
  input  logic [TIME_W-1:0]     in_now,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_allowed,
  output logic                  out_table_full,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                s1_valid_r;
  logic                s1_valid_nxt;
  logic [ID_W-1:0]     s1_id_r;
  logic [TIME_W-1:0]   s1_now_r;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                out_allowed_r;
  logic                out_table_full_r;
  logic [WINDOW_W-1:0] window_r;
  logic [WINDOW_W-1:0] window_nxt;
  logic [LIMIT_W-1:0]  limit_r;
  logic [LIMIT_W-1:0]  limit_nxt;
  logic                adv;
  logic                in_xfer;
  logic                res_allowed;
  logic                res_full;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_xfer  = in_valid && !in_stall;

  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_allowed    = out_allowed_r;
  assign out_table_full = out_table_full_r;

  pcwrl_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (adv),
    .id        (s1_id_r),
    .now       (s1_now_r),
    .window    (window_r),
    .limit     (limit_r),
    .allowed   (res_allowed),
    .table_full(res_full)
  );

  always_comb begin
    window_nxt = window_r;
    limit_nxt  = limit_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WINDOW: window_nxt = cfg_data;
        CFG_LIMIT:  limit_nxt  = cfg_data[LIMIT_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    s1_valid_nxt = in_xfer || (s1_valid_r && !adv);
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      window_r    <= WINDOW_RESET;
      limit_r     <= LIMIT_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      window_r    <= window_nxt;
      limit_r     <= limit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_id_r  <= in_client_id;
      s1_now_r <= in_now;
    end
    if (adv) begin
      out_allowed_r    <= res_allowed;
      out_table_full_r <= res_full;
    end
  end

  a_full_refuses: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_allowed_r && out_table_full_r))
    else $error("table_full result marked as admitted");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("pending request did not reach result register");

  a_stall_backs_up: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |-> in_stall)
    else $error("input not stalled while both stages are held");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with empty input stage");

endmodule

[src/pcwrl_entry.sv]
// pcwrl_entry: one client entry with its deadline slots, compares and update
// depends on pcwrl_pkg
module pcwrl_entry import pcwrl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ID_W-1:0]   id,
  input  logic [TIME_W-1:0] now,
  input  entry_upd_t        upd,
  output entry_stat_t       stat
);

  logic                        valid_r;
  logic                        valid_nxt;
  logic [ID_W-1:0]             client_r;
  logic [SLOTS_PER_CLIENT-1:0] live_r;
  logic [SLOTS_PER_CLIENT-1:0] live_nxt;
  logic [TIME_W-1:0]           dl_r [SLOTS_PER_CLIENT];
  logic [SLOTS_PER_CLIENT-1:0] keep;
  logic [LIVE_W-1:0]           cnt;
  logic                        found;
  logic [SLOT_IDX_W-1:0]       fidx;

  // slots still running after now
  always_comb begin
    for (int s = 0; s < SLOTS_PER_CLIENT; s++) begin
      keep[s] = live_r[s] && (dl_r[s] > now);
    end
  end

  always_comb begin
    cnt   = '0;
    found = 1'b0;
    fidx  = '0;
    for (int s = 0; s < SLOTS_PER_CLIENT; s++) begin
      cnt = cnt + LIVE_W'(keep[s]);
    end
    for (int s = SLOTS_PER_CLIENT - 1; s >= 0; s--) begin
      if (!keep[s]) begin
        found = 1'b1;
        fidx  = SLOT_IDX_W'(s);
      end
    end
  end

  always_comb begin
    stat.hit        = valid_r && (client_r == id);
    stat.avail      = !valid_r || (keep == '0);
    stat.live_cnt   = cnt;
    stat.free_found = found;
    stat.free_idx   = fidx;
  end

  always_comb begin
    valid_nxt = valid_r;
    live_nxt  = live_r;
    if (upd.commit) begin
      if (upd.claim) begin
        valid_nxt = 1'b1;
        live_nxt  = '0;
      end else begin
        live_nxt = keep;
      end
      if (upd.set_slot) begin
        live_nxt[upd.slot_idx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      live_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      live_r  <= live_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.commit && upd.claim) begin
      client_r <= upd.client;
    end
    if (upd.commit && upd.set_slot) begin
      dl_r[upd.slot_idx] <= upd.deadline;
    end
  end

endmodule

[src/pcwrl_table.sv]
// pcwrl_table: client table, entry selection and admission decision
// depends on pcwrl_pkg and pcwrl_entry
module pcwrl_table import pcwrl_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  logic [ID_W-1:0]     id,
  input  logic [TIME_W-1:0]   now,
  input  logic [WINDOW_W-1:0] window,
  input  logic [LIMIT_W-1:0]  limit,
  output logic                allowed,
  output logic                table_full
);

  entry_stat_t            stat [CLIENT_ENTRIES];
  entry_upd_t             upd  [CLIENT_ENTRIES];
  logic                   id_zero;
  logic                   hit_any;
  logic                   avail_any;
  logic [ENTRY_IDX_W-1:0] hit_idx;
  logic [ENTRY_IDX_W-1:0] avail_idx;
  logic [ENTRY_IDX_W-1:0] sel;
  logic                   claim;
  logic                   full;
  logic [LIVE_W-1:0]      sel_live;
  logic                   sel_found;
  logic [SLOT_IDX_W-1:0]  sel_slot;
  logic                   admit;
  logic [TIME_W:0]        sum;
  logic [TIME_W-1:0]      deadline;

  for (genvar e = 0; e < CLIENT_ENTRIES; e++) begin : g_entry
    pcwrl_entry u_entry (
      .clk  (clk),
      .rst_n(rst_n),
      .id   (id),
      .now  (now),
      .upd  (upd[e]),
      .stat (stat[e])
    );
  end

  // lowest-index match and lowest-index reusable entry
  always_comb begin
    hit_any   = 1'b0;
    avail_any = 1'b0;
    hit_idx   = '0;
    avail_idx = '0;
    for (int e = CLIENT_ENTRIES - 1; e >= 0; e--) begin
      if (stat[e].hit) begin
        hit_any = 1'b1;
        hit_idx = ENTRY_IDX_W'(e);
      end
      if (stat[e].avail) begin
        avail_any = 1'b1;
        avail_idx = ENTRY_IDX_W'(e);
      end
    end
  end

  always_comb begin
    id_zero = (id == '0);
    claim   = !hit_any;
    full    = !hit_any && !avail_any;
    sel     = hit_any ? hit_idx : avail_idx;
    if (claim) begin
      sel_live  = '0;
      sel_found = 1'b1;
      sel_slot  = '0;
    end else begin
      sel_live  = stat[sel].live_cnt;
      sel_found = stat[sel].free_found;
      sel_slot  = stat[sel].free_idx;
    end
    admit = !id_zero && !full && sel_found && (CMP_W'(sel_live) < CMP_W'(limit));
  end

  // saturating deadline
  always_comb begin
    sum      = {1'b0, now} + (TIME_W + 1)'(window);
    deadline = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
  end

  always_comb begin
    for (int e = 0; e < CLIENT_ENTRIES; e++) begin
      upd[e].commit   = go && !id_zero && !full && (sel == ENTRY_IDX_W'(e));
      upd[e].claim    = claim;
      upd[e].set_slot = admit;
      upd[e].slot_idx = sel_slot;
      upd[e].deadline = deadline;
      upd[e].client   = id;
    end
  end

  assign allowed    = admit;
  assign table_full = !id_zero && full;

endmodule

[tb/sv/tb_per_client_window_rate_limiter_core.sv]
// testbench for per_client_window_rate_limiter_core: directed and random requests
// checked against a cycle-free model of the client table; depends on pcwrl_pkg
// and the rtl of per_client_window_rate_limiter_core
`timescale 1ns / 1ps

module tb_per_client_window_rate_limiter_core;
  import pcwrl_pkg::*;

  localparam int POOL_SIZE    = 20;
  localparam int HOLD_CYCLES  = 80;
  localparam int RUN_LIMIT_NS = 400_000;

  typedef struct packed {
    logic allowed;
    logic table_full;
  } verdict_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ID_W-1:0]       in_client_id = '0;
  logic [TIME_W-1:0]     in_now = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_allowed;
  logic                  out_table_full;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index = CFG_WINDOW;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // model of the client table
  logic                tracked [CLIENT_ENTRIES];
  logic [ID_W-1:0]     owner   [CLIENT_ENTRIES];
  logic                held    [CLIENT_ENTRIES][SLOTS_PER_CLIENT];
  logic [TIME_W-1:0]   expiry  [CLIENT_ENTRIES][SLOTS_PER_CLIENT];
  logic [WINDOW_W-1:0] window_len;
  logic [LIMIT_W-1:0]  max_per_window;

  verdict_t          verdict_q [$];
  logic [ID_W-1:0]   client_pool [POOL_SIZE];
  logic [TIME_W-1:0] now_s;
  bit                send_gaps;
  bit                recv_gaps;
  bit                hold_off;
  int                errors;
  int                n_requests;
  int                n_admitted;
  int                n_full;
  int                cfg_writes;

  per_client_window_rate_limiter_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_client_id   (in_client_id),
    .in_now         (in_now),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_allowed    (out_allowed),
    .out_table_full (out_table_full),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("status: fail");
    $finish;
  end

  function automatic verdict_t admit_request(input logic [ID_W-1:0] id,
                                             input logic [TIME_W-1:0] t);
    verdict_t        v;
    int              pick_e;
    int              live;
    int              free_s;
    bit              busy;
    logic [TIME_W:0] sum;
    v = '0;
    pick_e = -1;
    live = 0;
    free_s = -1;
    if (id == '0) return v;
    for (int e = 0; e < CLIENT_ENTRIES; e++)
      if (pick_e < 0 && tracked[e] && owner[e] == id) pick_e = e;
    if (pick_e < 0) begin
      for (int e = 0; e < CLIENT_ENTRIES; e++) begin
        busy = 1'b0;
        for (int s = 0; s < SLOTS_PER_CLIENT; s++)
          if (held[e][s] && expiry[e][s] > t) busy = 1'b1;
        if (pick_e < 0 && (!tracked[e] || !busy)) pick_e = e;
      end
      if (pick_e < 0) begin
        v.table_full = 1'b1;
        return v;
      end
      tracked[pick_e] = 1'b1;
      owner[pick_e] = id;
      for (int s = 0; s < SLOTS_PER_CLIENT; s++) held[pick_e][s] = 1'b0;
    end
    for (int s = 0; s < SLOTS_PER_CLIENT; s++) begin
      if (held[pick_e][s] && expiry[pick_e][s] <= t) held[pick_e][s] = 1'b0;
      if (held[pick_e][s]) live++;
      else if (free_s < 0) free_s = s;
    end
    if (live >= int'(max_per_window) || free_s < 0) return v;
    sum = t + window_len;
    expiry[pick_e][free_s] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    held[pick_e][free_s] = 1'b1;
    v.allowed = 1'b1;
    return v;
  endfunction

  // one request transfer; called at a rising edge
  task automatic send_request(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] t);
    bit       stalled;
    verdict_t v;
    while (send_gaps && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_client_id <= id;
    in_now <= t;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    v = admit_request(id, t);
    verdict_q.push_back(v);
    n_requests++;
    if (v.allowed) n_admitted++;
    if (v.table_full) n_full++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    bit ready_seen;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      ready_seen = cfg_ready;
      @(posedge clk);
    end while (!ready_seen);
    cfg_valid <= 1'b0;
    if (idx == CFG_WINDOW) window_len = data;
    else max_per_window = data[LIMIT_W-1:0];
    cfg_writes++;
    @(posedge clk);
  endtask

  // result transfers happen at the next rising edge; sample before it
  always @(negedge clk) begin : check_results
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got allowed=%0b table_full=%0b",
                 $time, out_allowed, out_table_full);
      end else begin
        want = verdict_q.pop_front();
        if (out_allowed !== want.allowed) begin
          errors++;
          $display("%0t: allowed mismatch, expected %0b, got %0b",
                   $time, want.allowed, out_allowed);
        end
        if (out_table_full !== want.table_full) begin
          errors++;
          $display("%0t: table_full mismatch, expected %0b, got %0b",
                   $time, want.table_full, out_table_full);
        end
      end
    end
  end

  initial begin : drive_out_stall
    int n;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        for (n = 0; n < HOLD_CYCLES; n++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
        hold_off = 1'b0;
      end
      out_stall <= recv_gaps && ($urandom_range(99) < 36);
    end
  end

  task automatic test_zero_id();
    now_s = 32'd10;
    send_request('0, now_s);
  endtask

  task automatic test_window_zero();
    wait_idle();
    write_reg(CFG_WINDOW, 16'd0);
    write_reg(CFG_LIMIT, 16'd1);
    now_s = 32'd20;
    send_request(31'd3, now_s);
    send_request(31'd3, now_s);
  endtask

  // new client still claims the entry, here one whose slots all expired
  task automatic test_limit_zero();
    wait_idle();
    write_reg(CFG_LIMIT, 16'hfff0);
    now_s = 32'd30;
    send_request(31'd5, now_s);
  endtask

  task automatic test_slot_bound_and_table_full();
    wait_idle();
    write_reg(CFG_WINDOW, 16'hffff);
    write_reg(CFG_LIMIT, 16'ha5af);
    now_s = 32'd40;
    for (int i = 0; i < SLOTS_PER_CLIENT + 1; i++) send_request(31'h7fff_ffff, now_s);
    for (int k = 0; k < CLIENT_ENTRIES - 1; k++) send_request(31'h4000_0000 >> k, now_s);
    send_request(31'h0123_4567, now_s);
  endtask

  task automatic test_time_backward();
    wait_idle();
    write_reg(CFG_LIMIT, 16'd1);
    now_s = 32'd35;
    send_request(31'h4000_0000, now_s);
  endtask

  task automatic test_deadline_saturation();
    now_s = 32'hffff_fff0;
    send_request(31'h4000_0000, now_s);
    now_s = 32'hffff_ffff;
    send_request(31'h4000_0000, now_s);
    // free the saturated slot so later traffic at lower times gets the entry back
    wait_idle();
    write_reg(CFG_LIMIT, 16'd0);
    send_request(31'h4000_0000, now_s);
  endtask

  task automatic test_random_traffic(input int count, input logic [WINDOW_W-1:0] win,
                                     input logic [CFG_DATA_W-1:0] lim, input bit gaps);
    int              pick;
    int              step;
    logic [ID_W-1:0] id;
    wait_idle();
    write_reg(CFG_WINDOW, win);
    write_reg(CFG_LIMIT, lim);
    send_gaps = gaps;
    recv_gaps = gaps;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 4) id = '0;
      else if (pick < 9) id = ID_W'($urandom());
      else id = client_pool[$urandom_range(POOL_SIZE - 1)];
      step = $urandom_range(99);
      if (step >= 97) now_s = now_s + $urandom_range(1000, 1 << 20);
      else if (step >= 90) now_s = now_s + $urandom_range(4, 40);
      else if (step >= 55) now_s = now_s + $urandom_range(1, 3);
      send_request(id, now_s);
    end
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  // output held off long enough that the pipeline fills and stalls the input
  task automatic test_backpressure();
    wait_idle();
    write_reg(CFG_WINDOW, 16'd10);
    write_reg(CFG_LIMIT, 16'd3);
    send_gaps = 1'b0;
    hold_off = 1'b1;
    for (int i = 0; i < 40; i++) begin
      if ($urandom_range(99) < 40) now_s = now_s + 1;
      send_request(client_pool[$urandom_range(POOL_SIZE - 1)], now_s);
    end
    send_gaps = 1'b1;
  endtask

  initial begin : run_tests
    int guard;
    for (int e = 0; e < CLIENT_ENTRIES; e++) begin
      tracked[e] = 1'b0;
      for (int s = 0; s < SLOTS_PER_CLIENT; s++) held[e][s] = 1'b0;
    end
    window_len = WINDOW_RESET;
    max_per_window = LIMIT_RESET;
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    hold_off = 1'b0;
    errors = 0;
    n_requests = 0;
    n_admitted = 0;
    n_full = 0;
    cfg_writes = 0;
    now_s = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_id();
    test_window_zero();
    test_limit_zero();
    test_slot_bound_and_table_full();
    test_time_backward();
    test_deadline_saturation();

    for (int i = 0; i < POOL_SIZE; i++) client_pool[i] = ID_W'($urandom_range(1, 32'h7fff_ffff));
    now_s = 32'h8000_0000;
    test_random_traffic(90, 16'd8, 16'd3, 1'b1);
    test_random_traffic(90, WINDOW_W'($urandom_range(1, 40)),
                        CFG_DATA_W'($urandom_range(1, 8)), 1'b1);
    test_random_traffic(70, ($urandom_range(3) == 0) ? 16'd0 : WINDOW_W'($urandom_range(50, 300)),
                        CFG_DATA_W'($urandom()), 1'b1);
    test_random_traffic(70, 16'd4, 16'd2, 1'b0);
    test_backpressure();

    in_valid <= 1'b0;
    guard = 0;
    while (verdict_q.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (verdict_q.size() != 0) begin
      errors += verdict_q.size();
      $display("%0t: %0d results never arrived", $time, verdict_q.size());
    end

    $display("covered %0d requests: %0d admitted, %0d refused with table full",
             n_requests, n_admitted, n_full);
    $display("%0d register writes incl. window and limit extremes, one long output hold-off",
             cfg_writes);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
